// ===== rtl/abr_pkg.sv =====
// shared constants, register codes and control types for the boxcar averager
package abr_pkg;

    localparam int WINDOW_DEF   = 40;
    localparam int CHANNELS_DEF = 8;

    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 8;
    localparam int LEVEL_W    = 31;
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = 4;
    localparam int FILL_OUT_W = 6;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ABS_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ABS_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FRACTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_RELOAD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TARGET = 3'd6;

    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST     = 31'd6554;
    localparam logic [LEVEL_W-1:0] FLOOR_LEVEL_RST   = 31'd3277;
    localparam logic [LEVEL_W-1:0] STEP_ABS_LOW_RST  = 31'd1966;
    localparam logic [LEVEL_W-1:0] STEP_ABS_HIGH_RST = 31'd196608;
    localparam logic [FRAC_W-1:0]  STEP_FRACTION_RST = 16'd3277;
    localparam logic [CNT_W-1:0]   HOLD_RELOAD_RST   = 4'd6;
    localparam logic [CNT_W-1:0]   SETTLE_TARGET_RST = 4'd10;

    typedef struct packed {
        logic load;
        logic rd_last;
        logic mul;
        logic step;
        logic sum;
        logic div_init;
        logic div_step;
        logic fin;
        logic fe_wr;
        logic out_load;
    } abr_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic out_full;
    } abr_status_t;

endpackage

// ===== rtl/abr_if.sv =====
// input and result channel interfaces
interface abr_in_if;
    logic                                valid;
    logic                                ready;
    logic [abr_pkg::CHAN_W-1:0]          channel;
    logic signed [abr_pkg::SAMPLE_W-1:0] sample;
    logic [abr_pkg::GAIN_W-1:0]          gain_range;

    modport source (output valid, channel, sample, gain_range, input ready);
    modport sink (input valid, channel, sample, gain_range, output ready);
endinterface

interface abr_out_if;
    logic                                valid;
    logic                                ready;
    logic [abr_pkg::CHAN_W-1:0]          out_channel;
    logic signed [abr_pkg::SAMPLE_W-1:0] measurement;
    logic signed [abr_pkg::SAMPLE_W-1:0] window_average;
    logic [abr_pkg::FILL_OUT_W-1:0]      window_fill;
    logic                                averaging_on;

    modport source (output valid, out_channel, measurement, window_average, window_fill,
                    averaging_on, input ready);
    modport sink (input valid, out_channel, measurement, window_average, window_fill,
                  averaging_on, output ready);
endinterface

// ===== rtl/abr_ctrl.sv =====
// sequencing state machine for one sample beat
module abr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  abr_pkg::abr_status_t status,
    output abr_pkg::abr_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LAST  = 4'd1;
    localparam logic [3:0] S_LWAIT = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FE    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_LWAIT;
            end
            S_LWAIT:
            begin
                cmd.mul    = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                if (status.sum_done)
                begin
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_FE;
            end
            S_FE:
            begin
                cmd.fe_wr  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/abr_datapath.sv =====
// window stores, per-channel state, step detection, window sum and divider
module abr_datapath #(
    parameter int WINDOW   = abr_pkg::WINDOW_DEF,
    parameter int CHANNELS = abr_pkg::CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  abr_pkg::abr_cmd_t                     cmd,
    output abr_pkg::abr_status_t                  status,
    input  logic [abr_pkg::CHAN_W-1:0]            in_channel,
    input  logic signed [abr_pkg::SAMPLE_W-1:0]   in_sample,
    input  logic [abr_pkg::GAIN_W-1:0]            in_gain,
    input  logic                                  wr_en,
    input  logic [abr_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [abr_pkg::LEVEL_W-1:0]           wr_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [abr_pkg::CHAN_W-1:0]            out_channel,
    output logic signed [abr_pkg::SAMPLE_W-1:0]   measurement,
    output logic signed [abr_pkg::SAMPLE_W-1:0]   window_average,
    output logic [abr_pkg::FILL_OUT_W-1:0]        window_fill,
    output logic                                  averaging_on
);

    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = $clog2(WINDOW);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = abr_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int DCW   = $clog2(SW);
    localparam int PRW   = abr_pkg::SAMPLE_W + abr_pkg::FRAC_W + 1;

    // config registers
    logic [abr_pkg::LEVEL_W-1:0] low_reg, floor_reg, abs_lo_reg, abs_hi_reg;
    logic [abr_pkg::FRAC_W-1:0]  frac_reg;
    logic [abr_pkg::CNT_W-1:0]   reload_reg, target_reg;

    // per channel state
    logic [FW-1:0]                       fill_reg   [CHANNELS];
    logic [PW-1:0]                       head_reg   [CHANNELS];
    logic [abr_pkg::CNT_W-1:0]           hold_reg   [CHANNELS];
    logic [abr_pkg::CNT_W-1:0]           settle_reg [CHANNELS];
    logic                                mode_reg   [CHANNELS];
    logic signed [abr_pkg::SAMPLE_W-1:0] lastm_reg  [CHANNELS];

    // window stores
    logic signed [abr_pkg::SAMPLE_W-1:0] smem [DEPTH];
    logic [abr_pkg::GAIN_W-1:0]          gmem [DEPTH];
    logic signed [abr_pkg::SAMPLE_W-1:0] s_rd_reg;
    logic [abr_pkg::GAIN_W-1:0]          g_rd_reg;

    // current beat
    logic [CHW-1:0]                      ch_reg;
    logic signed [abr_pkg::SAMPLE_W-1:0] v_reg;
    logic [abr_pkg::GAIN_W-1:0]          g_reg;
    logic [FW-1:0]                       n_reg;
    logic [PW-1:0]                       hd_reg;
    logic [FW-1:0]                       num_reg;
    logic signed [abr_pkg::SAMPLE_W-1:0] last_reg;
    logic                                last_g0_reg;
    logic signed [PRW-1:0]               prod_reg;

    // sum and divide
    logic [FW-1:0]                       iss_reg;
    logic                                rdv_reg;
    logic signed [SW-1:0]                acc_reg;
    logic                                neg_reg;
    logic [SW-1:0]                       dq_reg;
    logic [FW-1:0]                       rem_reg;
    logic [DCW-1:0]                      dcnt_reg;

    // finish results
    logic signed [abr_pkg::SAMPLE_W-1:0] meas_reg;
    logic signed [abr_pkg::SAMPLE_W-1:0] avg_reg;
    logic                                on_reg;
    logic                                fe_reg;

    // output register
    logic                                ov_reg;
    logic [abr_pkg::CHAN_W-1:0]          o_ch_reg;
    logic signed [abr_pkg::SAMPLE_W-1:0] o_meas_reg;
    logic signed [abr_pkg::SAMPLE_W-1:0] o_avg_reg;
    logic [abr_pkg::FILL_OUT_W-1:0]      o_fill_reg;
    logic                                o_on_reg;

    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base, input logic [FW-1:0] idx);
        logic [PW:0] s;
        s = (PW+1)'(base) + (PW+1)'(idx);
        if (s >= (PW+1)'(WINDOW))
        begin
            s = s - (PW+1)'(WINDOW);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CHW-1:0] c, input logic [PW-1:0] p);
        return AW'(AW'(c) * AW'(WINDOW)) + AW'(p);
    endfunction

    // channel wraps modulo the channel count
    logic [CHW-1:0] ch_idx;
    always_comb
    begin
        ch_idx = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (in_channel == abr_pkg::CHAN_W'(k))
            begin
                ch_idx = CHW'(k % CHANNELS);
            end
        end
    end

    // step detection and append
    logic signed [PRW-1:0]   pct_full;
    logic signed [32:0]      pct;
    logic signed [33:0]      absth, pct34, th;
    logic signed [32:0]      dif;
    logic [32:0]             ad;
    logic signed [31:0]      low_s;
    logic                    skip, hit, clr;
    logic [abr_pkg::CNT_W-1:0] hc, hold_new;
    logic [FW-1:0]           nn, n_new;
    logic [PW-1:0]           hb, head_new, wp;

    always_comb
    begin
        pct_full = prod_reg + (prod_reg[PRW-1] ? PRW'(65535) : PRW'(0));
        pct      = pct_full[PRW-1:16];
        absth    = $signed({3'b000, last_g0_reg ? abs_lo_reg : abs_hi_reg});
        pct34    = {pct[32], pct};
        th       = (absth > pct34) ? absth : pct34;
        dif      = {v_reg[31], v_reg} - {last_reg[31], last_reg};
        ad       = dif[32] ? 33'(-dif) : 33'(dif);
        low_s    = $signed({1'b0, low_reg});
        skip     = (v_reg <= low_s) && (last_reg <= low_s);
        hit      = !skip && ($signed({1'b0, ad}) > th);
        hc       = hit ? reload_reg : hold_reg[ch_reg];
        clr      = (n_reg != '0) && (hc != '0);
        hold_new = clr ? hc - 1'b1 : hc;
        nn       = clr ? '0 : n_reg;
        hb       = clr ? '0 : hd_reg;
        if (nn < FW'(WINDOW))
        begin
            wp       = wrap(hb, nn);
            head_new = hb;
            n_new    = nn + 1'b1;
        end
        else
        begin
            wp       = hb;
            head_new = wrap(hb, FW'(1));
            n_new    = FW'(WINDOW);
        end
    end

    // divider step and average
    logic [FW:0]                         dt;
    logic                                dge;
    logic [SW-1:0]                       q_s;
    logic signed [abr_pkg::SAMPLE_W-1:0] avg_c;
    always_comb
    begin
        dt    = {rem_reg, dq_reg[SW-1]};
        dge   = dt >= {1'b0, num_reg};
        q_s   = neg_reg ? (~dq_reg + 1'b1) : dq_reg;
        avg_c = q_s[abr_pkg::SAMPLE_W-1:0];
    end

    // settle and averaging mode
    logic [abr_pkg::CNT_W-1:0]           settle_n;
    logic                                mode_n, on_c, fe_c;
    logic signed [abr_pkg::SAMPLE_W-1:0] lastm_n, meas_c;
    always_comb
    begin
        settle_n = settle_reg[ch_reg];
        mode_n   = mode_reg[ch_reg];
        lastm_n  = lastm_reg[ch_reg];
        meas_c   = v_reg;
        on_c     = 1'b0;
        fe_c     = 1'b0;
        if (g_reg == '0)
        begin
            settle_n = '0;
            meas_c   = avg_c;
        end
        else if (v_reg <= $signed({1'b0, floor_reg}))
        begin
            mode_n   = 1'b0;
            lastm_n  = v_reg;
            settle_n = '0;
        end
        else
        begin
            if (settle_reg[ch_reg] < target_reg)
            begin
                mode_n   = 1'b0;
                settle_n = settle_reg[ch_reg] + 1'b1;
            end
            if (mode_n)
            begin
                meas_c = avg_c;
                on_c   = 1'b1;
            end
            else if ((settle_n == target_reg) && (lastm_reg[ch_reg] > v_reg))
            begin
                mode_n = 1'b1;
                fe_c   = 1'b1;
            end
            else
            begin
                lastm_n = v_reg;
            end
        end
    end

    // store ports
    // a one-entry window only follows a clear or reset, so its second gain entry reads as zero
    logic                                s_we, g_we;
    logic [AW-1:0]                       s_wa, rd_a;
    logic signed [abr_pkg::SAMPLE_W-1:0] s_wd;
    logic [abr_pkg::GAIN_W-1:0]          g_wd;
    logic [FW-1:0]                       last_idx;
    always_comb
    begin
        g_we     = cmd.step | (cmd.fe_wr & fe_reg & (num_reg == FW'(1)));
        g_wd     = cmd.fe_wr ? '0 : g_reg;
        s_we     = cmd.step | (cmd.fin & fe_c) | (cmd.fe_wr & fe_reg);
        s_wa     = addr_of(ch_reg, wp);
        s_wd     = v_reg;
        if (cmd.fin)
        begin
            s_wa = addr_of(ch_reg, hd_reg);
            s_wd = lastm_reg[ch_reg];
        end
        else if (cmd.fe_wr)
        begin
            s_wa = addr_of(ch_reg, wrap(hd_reg, FW'(1)));
        end
        last_idx = (n_reg == '0) ? '0 : n_reg - 1'b1;
        if (cmd.rd_last)
        begin
            rd_a = addr_of(ch_reg, wrap(hd_reg, last_idx));
        end
        else
        begin
            rd_a = addr_of(ch_reg, wrap(hd_reg, (iss_reg < num_reg) ? iss_reg : '0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_wa] <= s_wd;
        end
        if (g_we)
        begin
            gmem[s_wa] <= g_wd;
        end
        s_rd_reg <= smem[rd_a];
        g_rd_reg <= gmem[rd_a];
    end

    // beat payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg <= ch_idx;
            v_reg  <= in_sample;
            g_reg  <= in_gain;
            n_reg  <= fill_reg[ch_idx];
            hd_reg <= head_reg[ch_idx];
        end
        if (cmd.mul)
        begin
            last_reg    <= s_rd_reg;
            last_g0_reg <= (g_rd_reg == '0);
            prod_reg    <= PRW'(s_rd_reg) * PRW'($signed({1'b0, frac_reg}));
        end
        if (cmd.step)
        begin
            hd_reg  <= head_new;
            num_reg <= n_new;
            iss_reg <= '0;
            acc_reg <= '0;
        end
        if (cmd.sum)
        begin
            if (iss_reg != num_reg)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            if (rdv_reg)
            begin
                acc_reg <= acc_reg + SW'(s_rd_reg);
            end
        end
        if (cmd.div_init)
        begin
            neg_reg  <= acc_reg[SW-1];
            dq_reg   <= acc_reg[SW-1] ? SW'(-acc_reg) : SW'(acc_reg);
            rem_reg  <= '0;
            dcnt_reg <= DCW'(SW - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg  <= dge ? FW'(dt - {1'b0, num_reg}) : FW'(dt);
            dq_reg   <= {dq_reg[SW-2:0], dge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.fin)
        begin
            meas_reg <= meas_c;
            avg_reg  <= avg_c;
            on_reg   <= on_c;
        end
        if (cmd.out_load)
        begin
            o_ch_reg   <= abr_pkg::CHAN_W'(ch_reg);
            o_meas_reg <= meas_reg;
            o_avg_reg  <= avg_reg;
            o_fill_reg <= abr_pkg::FILL_OUT_W'(num_reg);
            o_on_reg   <= on_reg;
        end
    end

    // control flags, config and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg    <= 1'b0;
            fe_reg     <= 1'b0;
            ov_reg     <= 1'b0;
            low_reg    <= abr_pkg::LOW_LEVEL_RST;
            floor_reg  <= abr_pkg::FLOOR_LEVEL_RST;
            abs_lo_reg <= abr_pkg::STEP_ABS_LOW_RST;
            abs_hi_reg <= abr_pkg::STEP_ABS_HIGH_RST;
            frac_reg   <= abr_pkg::STEP_FRACTION_RST;
            reload_reg <= abr_pkg::HOLD_RELOAD_RST;
            target_reg <= abr_pkg::SETTLE_TARGET_RST;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c]   <= '0;
                head_reg[c]   <= '0;
                hold_reg[c]   <= '0;
                settle_reg[c] <= '0;
                mode_reg[c]   <= 1'b0;
                lastm_reg[c]  <= '0;
            end
        end
        else
        begin
            rdv_reg <= cmd.sum && (iss_reg != num_reg);
            if (cmd.fin)
            begin
                fe_reg <= fe_c;
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (wr_en)
            begin
                case (wr_index)
                    abr_pkg::REG_LOW_LEVEL:     low_reg    <= wr_data;
                    abr_pkg::REG_FLOOR_LEVEL:   floor_reg  <= wr_data;
                    abr_pkg::REG_STEP_ABS_LOW:  abs_lo_reg <= wr_data;
                    abr_pkg::REG_STEP_ABS_HIGH: abs_hi_reg <= wr_data;
                    abr_pkg::REG_STEP_FRACTION: frac_reg   <= wr_data[abr_pkg::FRAC_W-1:0];
                    abr_pkg::REG_HOLD_RELOAD:   reload_reg <= wr_data[abr_pkg::CNT_W-1:0];
                    abr_pkg::REG_SETTLE_TARGET: target_reg <= wr_data[abr_pkg::CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                fill_reg[ch_reg] <= n_new;
                head_reg[ch_reg] <= head_new;
                if (n_reg != '0)
                begin
                    hold_reg[ch_reg] <= hold_new;
                end
            end
            if (cmd.fin)
            begin
                settle_reg[ch_reg] <= settle_n;
                mode_reg[ch_reg]   <= mode_n;
                lastm_reg[ch_reg]  <= lastm_n;
                if (fe_c)
                begin
                    fill_reg[ch_reg] <= FW'(2);
                end
            end
        end
    end

    assign status.sum_done = (iss_reg == num_reg) && !rdv_reg;
    assign status.div_done = (dcnt_reg == '0);
    assign status.out_full = ov_reg;

    assign out_valid      = ov_reg;
    assign out_channel    = o_ch_reg;
    assign measurement    = o_meas_reg;
    assign window_average = o_avg_reg;
    assign window_fill    = o_fill_reg;
    assign averaging_on   = o_on_reg;

endmodule

// ===== rtl/adaptive_boxcar_step_reset.sv =====
// top level of the per-channel boxcar averager with step reset
//
// samples: one beat per reading (channel, Q15.16 sample, gain range); the
// channel index wraps modulo CHANNELS. results: one beat per sample beat with
// the chosen measurement, the truncated window mean, the window fill and the
// averaging flag. wr_en/wr_index/wr_data write the seven level, threshold and
// counter registers; write them only while no beat is in flight.
// one beat is processed at a time. for each beat the window sum reads the
// sample store (40 entries per channel by default) one entry per cycle through
// its single read port, then a bit-serial divider computes the mean.
// the next sample beat is accepted as soon as the result sits in the output
// register; if the receiver stalls, a second result waits in the block until
// the output register is taken.
// reset sets the registers to their defaults and clears every channel's fill,
// hold, settle, mode and last measurement; the window stores are not cleared
// and need no sweep, so the block is ready right after reset.
module adaptive_boxcar_step_reset #(
    parameter int WINDOW   = abr_pkg::WINDOW_DEF,
    parameter int CHANNELS = abr_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    abr_in_if.sink                        samples,
    abr_out_if.source                     results,
    input  logic                          wr_en,
    input  logic [abr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [abr_pkg::LEVEL_W-1:0]   wr_data
);

    abr_pkg::abr_cmd_t    cmd;
    abr_pkg::abr_status_t status;

    abr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    abr_datapath #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_channel     (samples.channel),
        .in_sample      (samples.sample),
        .in_gain        (samples.gain_range),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .out_channel    (results.out_channel),
        .measurement    (results.measurement),
        .window_average (results.window_average),
        .window_fill    (results.window_fill),
        .averaging_on   (results.averaging_on)
    );

endmodule
